// ----- design/rsf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the RGB sharpen filter.
package rsf_pkg;

    // Pixel channel width and clamp limit
    localparam int CHAN_BITS = 8;
    localparam logic [CHAN_BITS-1:0] PIX_MAX = 8'd255;

    // Configuration register widths and reset values
    localparam int CFG_WIDTH_BITS     = 12;
    localparam int CFG_HEIGHT_BITS    = 16;
    localparam int CFG_DATA_BITS      = 16;
    localparam int CFG_WIDTH_MAX      = (1 << CFG_WIDTH_BITS) - 1;
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    // Default largest supported line length
    localparam int MAX_WIDTH_DEFAULT = 2048;

    // Request opcode
    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // Configuration register index
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } pixel_t;

    // Control from the sequencer to the datapath: advance/emit decisions
    // and, for the border, which neighbors are real (else the center repeats)
    typedef struct packed {
        logic advance;
        logic emit;
        logic last;
        logic use_up;
        logic use_dn;
        logic use_lf;
        logic use_rt;
    } ctrl_t;

    // Widest line actually reachable: the parameter or the register range
    function automatic int eff_width_max(input int max_width);
        return (max_width < CFG_WIDTH_MAX) ? max_width : CFG_WIDTH_MAX;
    endfunction

endpackage

// ----- design/rsf_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the RGB sharpen filter: pixel in, pixel out, config.
interface rsf_pix_in_if import rsf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [CHAN_BITS-1:0] red_in;
    logic [CHAN_BITS-1:0] green_in;
    logic [CHAN_BITS-1:0] blue_in;

    modport source (output valid, output op, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input op, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

interface rsf_pix_out_if import rsf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] red_out;
    logic [CHAN_BITS-1:0] green_out;
    logic [CHAN_BITS-1:0] blue_out;
    logic                 frame_last;

    modport source (output valid, output red_out, output green_out,
                    output blue_out, output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out,
                    input blue_out, input frame_last, output ready);
endinterface

interface rsf_cfg_if import rsf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    cfg_idx_t                 index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/rsf_line_mem.sv -----
`timescale 1ns / 1ps
// Two-line pixel store: one write and one registered read per cycle.
module rsf_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wdata;
        end
    end

    // Read port, new data forwarded on a same-address write
    always_ff @(posedge clk)
    begin
        if (we && (wr_addr == rd_addr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/rsf_ctrl.sv -----
`timescale 1ns / 1ps
// Frame sequencer: config registers, input/output position and warm-up.
module rsf_ctrl import rsf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr,
    input  cfg_idx_t                                cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                cfg_data,
    input  logic                                    step,
    input  op_t                                     op,
    output ctrl_t                                   ctl,
    output logic [$clog2(eff_width_max(MAX_WIDTH))-1:0] wr_col,
    output logic [$clog2(eff_width_max(MAX_WIDTH))-1:0] rd_col
);

    localparam int WMAX = eff_width_max(MAX_WIDTH);
    localparam int EW   = $clog2(WMAX + 1);
    localparam int AW   = $clog2(WMAX);
    localparam int HW   = CFG_HEIGHT_BITS;

    localparam logic [EW-1:0] W_RESET =
        EW'((FRAME_WIDTH_RESET < WMAX) ? FRAME_WIDTH_RESET : WMAX);
    localparam logic [HW-1:0] H_RESET = HW'(FRAME_HEIGHT_RESET);
    localparam logic [CFG_WIDTH_BITS-1:0] W_LIMIT = CFG_WIDTH_BITS'(WMAX);

    logic [EW-1:0] w_eff_reg, w_eff_next;
    logic [HW-1:0] h_eff_reg, h_eff_next;
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic          in_done_reg, in_done_next;
    logic [EW:0]   warm_reg, warm_next;
    logic          active_reg, active_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;

    logic [EW-1:0]             w_m1;
    logic [HW-1:0]             h_m1;
    logic                      in_wrap;
    logic                      out_wrap;
    logic                      out_end_row;
    logic                      warm_full;
    logic                      frame_end;
    logic [AW-1:0]             in_col_inc;
    logic [CFG_WIDTH_BITS-1:0] cfg_w;

    // Position decode
    always_comb
    begin
        w_m1        = w_eff_reg - 1'b1;
        h_m1        = h_eff_reg - 1'b1;
        in_wrap     = (EW'(in_col_reg) == w_m1);
        in_col_inc  = in_wrap ? '0 : AW'(in_col_reg + 1'b1);
        out_wrap    = (EW'(out_col_reg) == w_m1);
        out_end_row = (out_row_reg == h_m1);
        warm_full   = (warm_reg == ({1'b0, w_eff_reg} + 1'b1));
        cfg_w       = cfg_data[CFG_WIDTH_BITS-1:0];
    end

    // Per-request decisions
    always_comb
    begin
        ctl.advance = in_done_reg || (op == OP_PIXEL);
        ctl.emit    = ctl.advance && (active_reg || warm_full);
        ctl.last    = out_end_row && out_wrap;
        ctl.use_up  = (out_row_reg != '0);
        ctl.use_dn  = !out_end_row;
        ctl.use_lf  = (out_col_reg != '0);
        ctl.use_rt  = !out_wrap;
    end

    assign frame_end = step && ctl.emit && ctl.last;

    // Next state
    always_comb
    begin
        w_eff_next   = w_eff_reg;
        h_eff_next   = h_eff_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        warm_next    = warm_reg;
        active_next  = active_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    priority if (cfg_w == '0)
                        w_eff_next = EW'(1);
                    else if (cfg_w > W_LIMIT)
                        w_eff_next = EW'(WMAX);
                    else
                        w_eff_next = EW'(cfg_w);
                end
                REG_FRAME_HEIGHT:
                begin
                    h_eff_next = (cfg_data == '0) ? HW'(1) : cfg_data;
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            warm_next    = '0;
            active_next  = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (frame_end)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            warm_next    = '0;
            active_next  = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (step && ctl.advance)
        begin
            // input position; row stops counting once the frame is in
            in_col_next = in_col_inc;
            if (in_wrap && !in_done_reg)
            begin
                if (in_row_reg == h_m1)
                    in_done_next = 1'b1;
                else
                    in_row_next = in_row_reg + 1'b1;
            end
            // warm-up: one line plus one request before the first result
            if (!active_reg)
            begin
                warm_next = warm_reg + 1'b1;
                if (warm_full)
                    active_next = 1'b1;
            end
            // output position
            if (ctl.emit)
            begin
                if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
        else
        begin
            // idle cycle or early drain: position holds
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg   <= W_RESET;
            h_eff_reg   <= H_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            warm_reg    <= '0;
            active_reg  <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            w_eff_reg   <= w_eff_next;
            h_eff_reg   <= h_eff_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            warm_reg    <= warm_next;
            active_reg  <= active_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Line store column: write where we are, prefetch where we go next
    assign wr_col = in_col_reg;
    assign rd_col = in_col_next;

    // Checks
    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (EW'(in_col_reg) < w_eff_reg))
        else $error("input column beyond line width");

    a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_row_reg < h_eff_reg) && (EW'(out_col_reg) < w_eff_reg))
        else $error("output position outside the frame");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (out_row_reg == '0) && (out_col_reg == '0) &&
                      (in_col_reg == '0) && !active_reg && !in_done_reg)
        else $error("counters not cleared after frame end");

    a_early_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !ctl.advance && !cfg_wr) |=>
            $stable(in_col_reg) && $stable(warm_reg) && $stable(out_col_reg))
        else $error("early drain request changed state");

endmodule

// ----- design/rsf_sharpen.sv -----
`timescale 1ns / 1ps
// Border replication and per-channel 5-point sharpen with clamp.
module rsf_sharpen import rsf_pkg::*; (
    input  ctrl_t  ctl,
    input  pixel_t tap_up,
    input  pixel_t tap_dn,
    input  pixel_t tap_lf,
    input  pixel_t tap_rt,
    input  pixel_t tap_ctr,
    output pixel_t result
);

    pixel_t up, dn, lf, rt;

    // 5*c - u - d - l - r, clamped to 0..255
    function automatic logic [CHAN_BITS-1:0] sharpen_ch(
        input logic [CHAN_BITS-1:0] c,
        input logic [CHAN_BITS-1:0] u,
        input logic [CHAN_BITS-1:0] d,
        input logic [CHAN_BITS-1:0] l,
        input logic [CHAN_BITS-1:0] r
    );
        logic [CHAN_BITS+3:0] acc;
        acc = {2'b00, c, 2'b00} + {4'b0000, c}
            - {4'b0000, u} - {4'b0000, d} - {4'b0000, l} - {4'b0000, r};
        priority if (acc[CHAN_BITS+3])
            return '0;
        else if (|acc[CHAN_BITS+2:CHAN_BITS])
            return PIX_MAX;
        else
            return acc[CHAN_BITS-1:0];
    endfunction

    // Replace out-of-frame neighbors by the center
    always_comb
    begin
        up = ctl.use_up ? tap_up : tap_ctr;
        dn = ctl.use_dn ? tap_dn : tap_ctr;
        lf = ctl.use_lf ? tap_lf : tap_ctr;
        rt = ctl.use_rt ? tap_rt : tap_ctr;
    end

    always_comb
    begin
        result.red   = sharpen_ch(tap_ctr.red, up.red, dn.red, lf.red, rt.red);
        result.green = sharpen_ch(tap_ctr.green, up.green, dn.green,
                                  lf.green, rt.green);
        result.blue  = sharpen_ch(tap_ctr.blue, up.blue, dn.blue,
                                  lf.blue, rt.blue);
    end

endmodule

// ----- design/rgb_sharpen_3x3_filter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the RGB 3x3 sharpen filter with border replication.
// Takes one request per clock: pix_in is ready whenever the output register is
// empty or being taken this cycle, so a result waiting on pix_out stops the
// next request. A pixel request (op = pixel) writes the line store; once a
// frame's W*H pixels are in, pixel and drain requests both advance the window.
// Pixel j leaves on the request that brings the frame's request count to
// j + W + 2 (one line plus one pixel), registered on acceptance; so W + 1 drain
// requests after the last pixel flush the frame, the final result carrying
// frame_last. A drain request that comes before the frame's last pixel is
// accepted and dropped. The line store is one dual-line memory, one write and
// one registered read per clock; its next column is fetched ahead, which keeps
// the rate at one request per clock for every width. The store needs no
// clearing after reset. Writing frame_width or frame_height (only while idle)
// restarts the frame; config writes are always taken.
module rgb_sharpen_3x3_filter_unit import rsf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    rsf_pix_in_if.sink    pix_in,
    rsf_pix_out_if.source pix_out,
    rsf_cfg_if.sink       cfg
);

    localparam int WMAX   = eff_width_max(MAX_WIDTH);
    localparam int AW     = $clog2(WMAX);
    localparam int PIX_W  = $bits(pixel_t);
    localparam int LINE_W = 2 * PIX_W;

    ctrl_t             ctl;
    logic              in_ready;
    logic              accept;
    logic              advance_we;
    logic [AW-1:0]     wr_col;
    logic [AW-1:0]     rd_col;
    logic [LINE_W-1:0] line_q;
    pixel_t            pix_new;
    pixel_t            near_q;
    pixel_t            far_q;
    pixel_t            sharp;

    // window taps
    pixel_t x_d1_reg;
    pixel_t a_d1_reg;
    pixel_t a_d2_reg;
    pixel_t b_d1_reg;

    // output register
    logic   out_valid_reg;
    pixel_t out_pix_reg;
    logic   out_last_reg;

    // Handshake
    assign in_ready     = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = in_ready;
    assign accept       = pix_in.valid && in_ready;
    assign cfg.ready    = 1'b1;
    assign advance_we   = accept && ctl.advance;

    assign pix_new = '{red: pix_in.red_in, green: pix_in.green_in,
                       blue: pix_in.blue_in};

    // Sequencer
    rsf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .step      (accept),
        .op        (pix_in.op),
        .ctl       (ctl),
        .wr_col    (wr_col),
        .rd_col    (rd_col)
    );

    // Line store: upper half one line back, lower half two lines back
    rsf_line_mem #(
        .DEPTH  (WMAX),
        .DATA_W (LINE_W)
    ) u_line_mem (
        .clk     (clk),
        .we      (advance_we),
        .wr_addr (wr_col),
        .wdata   ({pix_new, near_q}),
        .rd_addr (rd_col),
        .rdata   (line_q)
    );

    assign near_q = line_q[LINE_W-1:PIX_W];
    assign far_q  = line_q[PIX_W-1:0];

    // Window shift on every advancing request
    always_ff @(posedge clk)
    begin
        if (advance_we)
        begin
            x_d1_reg <= pix_new;
            a_d1_reg <= near_q;
            a_d2_reg <= a_d1_reg;
            b_d1_reg <= far_q;
        end
    end

    // Kernel
    rsf_sharpen u_sharpen (
        .ctl     (ctl),
        .tap_up  (b_d1_reg),
        .tap_dn  (x_d1_reg),
        .tap_lf  (a_d2_reg),
        .tap_rt  (near_q),
        .tap_ctr (a_d1_reg),
        .result  (sharp)
    );

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (accept && ctl.emit)
        begin
            out_pix_reg  <= sharp;
            out_last_reg <= ctl.last;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.red_out    = out_pix_reg.red;
    assign pix_out.green_out  = out_pix_reg.green;
    assign pix_out.blue_out   = out_pix_reg.blue;
    assign pix_out.frame_last = out_last_reg;

endmodule
